// ----- hw/rtl/swm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    // Depth of the sample history and derived widths.
    localparam int WINDOW_MAX = 8;
    localparam int AGE_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

    // Field widths fixed by the stream format.
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 4;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [AGE_W-1:0]           t_age;
    typedef logic [CNT_W-1:0]           t_count;
    typedef logic [LEN_W-1:0]           t_len;

    localparam t_len LEN_RESET = t_len'(4);

    // One stored sample together with its age (0 is the newest).
    typedef struct packed {
        t_sample value;
        t_age    age;
    } t_entry;

    // Entry handed to the left neighbor.
    typedef struct packed {
        t_entry entry;
        logic   valid;
    } t_nbr;

    // Remaining element after the oldest is dropped, handed to the right.
    typedef struct packed {
        t_entry entry;
        logic   valid;
        logic   le;
    } t_rem;

    // Broadcast to every cell.
    typedef struct packed {
        logic    load;
        t_sample sample;
        t_count  n;
        t_count  target;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/swm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface swm_sample_if;
    logic                 valid;
    logic                 ready;
    swm_pkg::t_sample     sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swm_median_if;
    logic                 valid;
    logic                 ready;
    swm_pkg::t_sample     median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

interface swm_cfg_if;
    logic                 valid;
    logic                 ready;
    swm_pkg::t_len        window_len;

    modport source (output valid, output window_len, input ready);
    modport sink   (input valid, input window_len, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/swm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module swm_cell (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire swm_pkg::t_age       i_reset_age,
    input  wire swm_pkg::t_cell_ctl  i_ctl,
    input  wire                      i_seen,
    output logic                     o_seen,
    input  wire swm_pkg::t_rem       i_left,
    output swm_pkg::t_rem            o_rem,
    input  wire swm_pkg::t_nbr       i_right,
    output swm_pkg::t_nbr            o_self,
    input  wire swm_pkg::t_count     i_count,
    output swm_pkg::t_count          o_count,
    output swm_pkg::t_sample         o_hit_value
);

    swm_pkg::t_entry r_entry;
    swm_pkg::t_entry n_entry;
    swm_pkg::t_entry rem_entry;
    logic            oldest;
    logic            seen_incl;
    logic            rem_valid;
    logic            rem_le;
    logic            sel;
    logic            hit;

    // The oldest entry leaves the chain; cells at or after it take the
    // right neighbor as their remaining element.
    assign oldest    = (r_entry.age == swm_pkg::t_age'(swm_pkg::WINDOW_MAX - 1));
    assign seen_incl = i_seen | oldest;
    assign o_seen    = seen_incl;

    assign rem_entry = seen_incl ? i_right.entry : r_entry;
    assign rem_valid = seen_incl ? i_right.valid : 1'b1;
    assign rem_le    = rem_valid && ($signed(rem_entry.value) <= $signed(i_ctl.sample));

    assign o_rem  = '{entry: rem_entry, valid: rem_valid, le: rem_le};
    assign o_self = '{entry: r_entry, valid: 1'b1};

    always_comb begin
        if (rem_le) begin
            n_entry.value = rem_entry.value;
            n_entry.age   = rem_entry.age + swm_pkg::t_age'(1);
        end else if (i_left.le) begin
            n_entry.value = i_ctl.sample;
            n_entry.age   = '0;
        end else begin
            n_entry.value = i_left.entry.value;
            n_entry.age   = i_left.entry.age + swm_pkg::t_age'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.value <= '0;
            r_entry.age   <= i_reset_age;
        end else if (i_ctl.load) begin
            r_entry <= n_entry;
        end
    end

    // Rank count among the entries young enough to be in the window.
    assign sel         = (swm_pkg::t_count'(r_entry.age) < i_ctl.n);
    assign o_count     = i_count + swm_pkg::t_count'(sel);
    assign hit         = sel && (i_count == i_ctl.target);
    assign o_hit_value = hit ? r_entry.value : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/sliding_window_median.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel    | Dir | Payload              | Notes
// -----------+-----+----------------------+---------------------------------
// i_sample_ch| in  | sample, 16b signed   | one request per sample
// o_median_ch| out | median, 16b signed   | one request per accepted sample
// i_cfg_ch   | in  | window_len, 4b       | always ready, write while idle
//
// One sample is taken every cycle while the output does not stall; its median
// is read from the sorted cell row and then held in the output register. The
// row drops the oldest sample and inserts the new one in a single update.
// Synchronous active-low reset fills the row with zeros aged 0 to 7 and sets
// the window length to 4. When the output is stalled, one further result can
// wait in the cell row before the sample channel deasserts ready.

module sliding_window_median (
    input  wire           i_clk,
    input  wire           i_rst_n,
    swm_sample_if.sink    i_sample_ch,
    swm_median_if.source  o_median_ch,
    swm_cfg_if.sink       i_cfg_ch
);

    localparam int N = swm_pkg::WINDOW_MAX;

    swm_pkg::t_len      r_len;
    logic               r_pending;
    logic               n_pending;
    logic               r_out_valid;
    logic               n_out_valid;
    swm_pkg::t_sample   r_median;
    swm_pkg::t_sample   n_median;

    logic               accept;
    logic               out_load;
    swm_pkg::t_count    n_eff;
    swm_pkg::t_cell_ctl ctl;

    // Chain nets between neighboring cells.
    logic               seen   [N+1];
    swm_pkg::t_rem      rem    [N+1];
    swm_pkg::t_nbr      nbr    [N+1];
    swm_pkg::t_count    count  [N+1];
    swm_pkg::t_sample   hitval [N];

    // Config register; user writes only while the block idles, not enforced.
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= swm_pkg::LEN_RESET;
        end else if (i_cfg_ch.valid) begin
            r_len <= i_cfg_ch.window_len;
        end
    end

    // A zero length acts as one, a length above the history depth saturates.
    always_comb begin
        if (r_len == '0) begin
            n_eff = swm_pkg::t_count'(1);
        end else if (32'(r_len) > N) begin
            n_eff = swm_pkg::t_count'(N);
        end else begin
            n_eff = swm_pkg::t_count'(r_len);
        end
    end

    // The cells hold a result not yet moved to the output register while
    // r_pending is set; a new sample may enter only if that result moves now.
    assign out_load          = r_pending && (!r_out_valid || o_median_ch.ready);
    assign i_sample_ch.ready = !r_pending || out_load;
    assign accept            = i_sample_ch.valid && i_sample_ch.ready;

    assign ctl.load   = accept;
    assign ctl.sample = i_sample_ch.sample;
    assign ctl.n      = n_eff;
    assign ctl.target = (n_eff - swm_pkg::t_count'(1)) >> 1;

    // Chain boundaries: nothing is removed before the first cell, the first
    // cell sees a left side that is never larger than the new sample, and
    // nothing lies beyond the last cell.
    assign seen[0]  = 1'b0;
    assign rem[0]   = '{entry: '0, valid: 1'b0, le: 1'b1};
    assign nbr[N]   = '{entry: '0, valid: 1'b0};
    assign count[0] = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        swm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_reset_age (swm_pkg::t_age'(g)),
            .i_ctl       (ctl),
            .i_seen      (seen[g]),
            .o_seen      (seen[g+1]),
            .i_left      (rem[g]),
            .o_rem       (rem[g+1]),
            .i_right     (nbr[g+1]),
            .o_self      (nbr[g]),
            .i_count     (count[g]),
            .o_count     (count[g+1]),
            .o_hit_value (hitval[g])
        );
    end

    // Exactly one cell reports a hit; the rest drive zero.
    always_comb begin
        n_median = '0;
        for (int k = 0; k < N; k++) begin
            n_median = n_median | hitval[k];
        end
    end

    always_comb begin
        if (accept) begin
            n_pending = 1'b1;
        end else if (out_load) begin
            n_pending = 1'b0;
        end else begin
            n_pending = r_pending;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_median_ch.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_median <= n_median;
        end
    end

    assign o_median_ch.valid  = r_out_valid;
    assign o_median_ch.median = r_median;

endmodule

`default_nettype wire
